[design/svs_pkg.sv]
`default_nettype none

package svs_pkg;

    // Width of one value word.
    localparam int VALUE_W = 64;

    // Default capacity of the sorting chain.
    localparam int MAX_ITEMS_DEF = 32;

    // One slot of the chain: a value and a flag that says it is occupied.
    typedef struct packed {
        logic                      vld;
        logic signed [VALUE_W-1:0] val;
    } svs_link_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_DRAIN
    } svs_state_t;

endpackage

`default_nettype wire

[design/svs_cell.sv]
`default_nettype none

// One insertion cell. In load mode it keeps the smaller of its held value and
// the arriving value and hands the larger one to the right. In shift mode it
// takes over the held value of its right neighbor.
module svs_cell
    import svs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      shift,
    input  wire svs_link_t in_link,
    input  wire svs_link_t nb_held,
    output svs_link_t      held,
    output svs_link_t      pass
);

    logic                      held_vld_reg;
    logic                      held_vld_next;
    logic signed [VALUE_W-1:0] held_val_reg;
    logic signed [VALUE_W-1:0] held_val_next;
    logic                      pass_vld_reg;
    logic                      pass_vld_next;
    logic signed [VALUE_W-1:0] pass_val_reg;
    logic signed [VALUE_W-1:0] pass_val_next;

    always_comb
    begin
        held_vld_next = held_vld_reg;
        held_val_next = held_val_reg;
        pass_vld_next = 1'b0;
        pass_val_next = in_link.val;
        if (shift)
        begin
            held_vld_next = nb_held.vld;
            held_val_next = nb_held.val;
        end
        else if (in_link.vld)
        begin
            if (!held_vld_reg)
            begin
                held_vld_next = 1'b1;
                held_val_next = in_link.val;
            end
            else if (in_link.val < held_val_reg)
            begin
                held_val_next = in_link.val;
                pass_vld_next = 1'b1;
                pass_val_next = held_val_reg;
            end
            else
            begin
                pass_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_vld_reg <= 1'b0;
            pass_vld_reg <= 1'b0;
        end
        else
        begin
            held_vld_reg <= held_vld_next;
            pass_vld_reg <= pass_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_val_reg <= held_val_next;
        pass_val_reg <= pass_val_next;
    end

    assign held.vld = held_vld_reg;
    assign held.val = held_val_reg;
    assign pass.vld = pass_vld_reg;
    assign pass.val = pass_val_reg;

endmodule

`default_nettype wire

[design/signed_value_sorter_top.sv]
// Sorts a batch of signed 64-bit words in ascending order. Words enter one per
// cycle while in_stall is low; the word with batch_end set closes the batch.
// The block then stalls its input while the insertion chain settles, until no
// word is still moving between cells, and then emits the batch smallest first,
// one word per cycle when the output is not stalled, with run_last on the final
// word. Words beyond MAX_ITEMS in one batch are dropped, and every result of
// that batch then carries overflowed. The next batch may start loading while
// the final result of the previous one still waits at the output.
`default_nettype none

module signed_value_sorter_top
    import svs_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [VALUE_W-1:0] sample_value,
    input  wire logic                      batch_end,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [VALUE_W-1:0]      sorted_value,
    output logic                           run_last,
    output logic                           overflowed
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Cell i reads link[i] and drives link[i+1]; link[0] is the entry register.
    svs_link_t link [0:MAX_ITEMS];
    svs_link_t held [0:MAX_ITEMS];

    svs_state_t state_reg;
    svs_state_t state_next;

    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] fill_count_next;
    logic             drop_flag_reg;
    logic             drop_flag_next;

    logic                      ent_vld_reg;
    logic                      ent_vld_next;
    logic signed [VALUE_W-1:0] ent_val_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [VALUE_W-1:0] sorted_value_reg;
    logic                      run_last_reg;
    logic                      overflowed_reg;

    logic in_take;
    logic store_room;
    logic pop;
    logic chain_busy;

    assign in_stall   = (state_reg != ST_LOAD);
    assign in_take    = in_valid && !in_stall;
    assign store_room = (fill_count_reg != CNT_MAX);
    assign pop        = (state_reg == ST_DRAIN) && (!out_valid_reg || !out_stall);

    assign link[0].vld = ent_vld_reg;
    assign link[0].val = ent_val_reg;

    // The slot past the last cell is always empty: shifting fills it with nothing.
    assign held[MAX_ITEMS].vld = 1'b0;
    assign held[MAX_ITEMS].val = '0;

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        svs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (pop),
            .in_link (link[i]),
            .nb_held (held[i+1]),
            .held    (held[i]),
            .pass    (link[i+1])
        );
    end

    // Any word still moving between cells means the chain is not yet ordered.
    always_comb
    begin
        chain_busy = 1'b0;
        for (int i = 0; i <= MAX_ITEMS; i++)
        begin
            chain_busy = chain_busy | link[i].vld;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        drop_flag_next  = drop_flag_reg;
        ent_vld_next    = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_take)
                begin
                    if (store_room)
                    begin
                        ent_vld_next    = 1'b1;
                        fill_count_next = fill_count_reg + CNT_ONE;
                    end
                    else
                    begin
                        drop_flag_next = 1'b1;
                    end
                    if (batch_end)
                    begin
                        state_next = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE:
            begin
                if (!chain_busy)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pop)
                begin
                    fill_count_next = fill_count_reg - CNT_ONE;
                    if (fill_count_reg == CNT_ONE)
                    begin
                        drop_flag_next = 1'b0;
                        state_next     = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            fill_count_reg <= '0;
            drop_flag_reg  <= 1'b0;
            ent_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            drop_flag_reg  <= drop_flag_next;
            ent_vld_reg    <= ent_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ent_val_reg <= sample_value;
        end
        if (pop)
        begin
            sorted_value_reg <= held[0].val;
            run_last_reg     <= (fill_count_reg == CNT_ONE);
            overflowed_reg   <= drop_flag_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign run_last     = run_last_reg;
    assign overflowed   = overflowed_reg;

endmodule

`default_nettype wire

[design/svs_checker.sv]
`default_nettype none

module svs_checker
    import svs_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      batch_end,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic signed [VALUE_W-1:0] sorted_value,
    input wire logic                      run_last,
    input wire logic                      overflowed
);

    // Closing a batch stops input until the batch has been emitted.
    a_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && batch_end |=> in_stall)
        else $error("input not stalled after the batch closed");

    // While input is open, only the final word of the previous batch may wait.
    a_open_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_stall |-> run_last)
        else $error("non-final result pending while loading");

    // The overflow mark is the same on every word of one batch.
    a_flag_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last ##1 out_valid |-> $stable(overflowed))
        else $error("overflow mark changed within a batch");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sorted_value)
            && $stable(run_last))
        else $error("stalled result changed");

endmodule

bind signed_value_sorter_top svs_checker u_svs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .batch_end    (batch_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .run_last     (run_last),
    .overflowed   (overflowed)
);

`default_nettype wire

[tb/sv/sorted_batch_checker.sv]
`default_nettype none

module sorted_batch_checker
    import svs_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic                      in_stall,
    input  wire logic signed [VALUE_W-1:0] sample_value,
    input  wire logic                      batch_end,
    input  wire logic                      out_valid,
    input  wire logic                      out_stall,
    input  wire logic signed [VALUE_W-1:0] sorted_value,
    input  wire logic                      run_last,
    input  wire logic                      overflowed,
    output int                             fail_count,
    output int                             pending_count,
    output int                             checked_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      dropped;
    } sorted_word_t;

    // Words of the batch still being loaded, and the words owed by closed batches.
    logic signed [VALUE_W-1:0] open_batch[$];
    logic                      open_dropped;
    sorted_word_t              sorted_words_due[$];

    // Sorts the open batch in ascending signed order and queues it as expected output.
    function automatic void close_batch();
        logic signed [VALUE_W-1:0] key;
        sorted_word_t              word;
        int                        k;
        for (int i = 1; i < open_batch.size(); i++)
        begin
            key = open_batch[i];
            k   = i;
            while (k > 0 && key < open_batch[k-1])
            begin
                open_batch[k] = open_batch[k-1];
                k--;
            end
            open_batch[k] = key;
        end
        for (int i = 0; i < open_batch.size(); i++)
        begin
            word.value   = open_batch[i];
            word.last    = (i == open_batch.size() - 1);
            word.dropped = open_dropped;
            sorted_words_due.push_back(word);
        end
        open_batch.delete();
        open_dropped = 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sorted_word_t due;
        if (!rst_n)
        begin
            open_batch.delete();
            sorted_words_due.delete();
            open_dropped  = 1'b0;
            fail_count    = 0;
            checked_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (open_batch.size() < MAX_ITEMS)
                    open_batch.push_back(sample_value);
                else
                    open_dropped = 1'b1;
                if (batch_end)
                    close_batch();
            end
            if (out_valid && !out_stall)
            begin
                if (sorted_words_due.size() == 0)
                begin
                    $error("unexpected sorted word %0d with nothing pending", sorted_value);
                    fail_count++;
                end
                else
                begin
                    due = sorted_words_due.pop_front();
                    checked_count++;
                    if (sorted_value !== due.value)
                    begin
                        $error("sorted_value: expected %0d, got %0d", due.value, sorted_value);
                        fail_count++;
                    end
                    if (run_last !== due.last)
                    begin
                        $error("run_last: expected %0b, got %0b", due.last, run_last);
                        fail_count++;
                    end
                    if (overflowed !== due.dropped)
                    begin
                        $error("overflowed: expected %0b, got %0b", due.dropped, overflowed);
                        fail_count++;
                    end
                end
            end
            pending_count = sorted_words_due.size();
        end
    end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import svs_pkg::*;

    // Capacity of the block under test; the checker is built with the same value.
    localparam int CAPACITY = MAX_ITEMS_DEF;

    // Number of random words to offer after the directed batches.
    localparam int RANDOM_WORDS = 220;

    // Length of the one long hold-off on the output side, in cycles. It is far
    // longer than a full batch, so the block fills up and must stall its input.
    localparam int LONG_HOLD = 400;

    // Watchdog limit in cycles. It lies well above the slowest correct run (every
    // word after a long sender gap, every result after a long receiver stall,
    // every batch paying the full settle time, plus the hold-off).
    localparam int CYCLE_LIMIT = 250000;

    localparam logic signed [VALUE_W-1:0] MAX_VALUE = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VALUE_W-1:0] MIN_VALUE = 64'sh8000_0000_0000_0000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      batch_end;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      run_last;
    logic                      overflowed;

    int fail_count;
    int pending_count;
    int checked_count;

    // Shared between the stimulus and the receiver process. The stimulus raises
    // holds_requested; the receiver serves the hold and counts holds_served.
    int holds_requested;
    int holds_served;
    bit no_idle;

    // Run statistics for the closing summary.
    int words_offered;
    int batches_sent;
    int overflow_batches;
    int single_batches;

    signed_value_sorter_top #(
        .MAX_ITEMS (CAPACITY)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .batch_end    (batch_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .run_last     (run_last),
        .overflowed   (overflowed)
    );

    // The checker watches both channels, predicts the sorted output of every
    // closed batch and compares each accepted word against it.
    sorted_batch_checker #(
        .MAX_ITEMS (CAPACITY)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample_value  (sample_value),
        .batch_end     (batch_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sorted_value  (sorted_value),
        .run_last      (run_last),
        .overflowed    (overflowed),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d sorted words still pending",
                 CYCLE_LIMIT, pending_count);
        $display("Simulation FAILED");
        $finish;
    end

    // Idle lengths: mostly none, often a few cycles, now and then a long stretch.
    function automatic int gap_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 50);
    endfunction

    // Random word values. Full-range patterns exercise every bit; a narrow band
    // around zero produces plenty of duplicates; the rest are zero, minus one, or
    // at or near the extremes, where a signed compare done as unsigned would go wrong.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned roll;
        int          small_val;
        roll      = $urandom_range(0, 99);
        small_val = $urandom_range(0, 16);
        if (roll < 55)
            return {$urandom, $urandom};
        else if (roll < 80)
            return VALUE_W'(small_val - 8);
        else if (roll < 90)
        begin
            unique case ($urandom_range(0, 3))
                0:       return MAX_VALUE;
                1:       return MIN_VALUE;
                2:       return '0;
                default: return -64'sd1;
            endcase
        end
        else if (roll < 95)
            return MAX_VALUE - VALUE_W'($urandom_range(0, 3));
        else
            return MIN_VALUE + VALUE_W'($urandom_range(0, 3));
    endfunction

    // Batch sizes: mostly short, some medium, some up to capacity, and about
    // one in ten past capacity so that words get dropped.
    function automatic int pick_batch_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return $urandom_range(1, 8);
        else if (roll < 80)
            return $urandom_range(9, 20);
        else if (roll < 90)
            return $urandom_range(21, CAPACITY);
        else
            return $urandom_range(CAPACITY + 1, CAPACITY + 8);
    endfunction

    // Offers one word and holds it until the block accepts it. The task is entered
    // and left at a falling edge, so the payload only ever changes there. While
    // the sender idles, the payload carries junk that the block must ignore.
    task automatic offer_word(input logic signed [VALUE_W-1:0] value, input logic last);
        int gap;
        sample_value = value;
        batch_end    = last;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        words_offered++;
        @(negedge clk);
        gap = no_idle ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid     = 1'b0;
            sample_value = {$urandom, $urandom};
            batch_end    = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
    endtask

    // Sends one batch; the last word carries batch_end.
    task automatic send_batch(input logic signed [VALUE_W-1:0] words[$]);
        for (int i = 0; i < words.size(); i++)
            offer_word(words[i], i == words.size() - 1);
        batches_sent++;
        if (words.size() > CAPACITY)
            overflow_batches++;
        if (words.size() == 1)
            single_batches++;
    endtask

    // Stops offering and waits at a falling edge until every expected word is out.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Receiver. It decides out_stall at every falling edge: random bursts of
    // stall, none at all while no_idle is set, and one long counted hold-off
    // whenever the stimulus asks for it.
    initial
    begin
        int stall_left;
        stall_left   = 0;
        holds_served = 0;
        out_stall    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_requested)
            begin
                out_stall = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
                holds_served++;
            end
            else if (no_idle)
            begin
                out_stall  = 1'b0;
                stall_left = 0;
            end
            else
            begin
                if (stall_left == 0)
                    stall_left = gap_len();
                if (stall_left > 0)
                begin
                    out_stall = 1'b1;
                    stall_left--;
                end
                else
                    out_stall = 1'b0;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic signed [VALUE_W-1:0] words[$];
        int                        size;
        int                        batch_idx;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        sample_value     = '0;
        batch_end        = 1'b0;
        no_idle          = 1'b0;
        holds_requested  = 0;
        words_offered    = 0;
        batches_sent     = 0;
        overflow_batches = 0;
        single_batches   = 0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Single-word batches at both extremes come first, then a
        // mixed batch with the extremes, zero, minus one, alternating bit patterns
        // and duplicates, then a batch in reverse order and one already in order.
        words = '{MAX_VALUE};
        send_batch(words);
        words = '{MIN_VALUE};
        send_batch(words);
        words = '{64'sd0, -64'sd1, MAX_VALUE, MIN_VALUE, 64'shAAAA_AAAA_AAAA_AAAA,
                  64'sh5555_5555_5555_5555, 64'sd1, 64'sd0, -64'sd1};
        send_batch(words);
        words = '{64'sd5, 64'sd4, 64'sd3, -64'sd2, MIN_VALUE};
        send_batch(words);
        words = '{MIN_VALUE, -64'sd7, 64'sd7, MAX_VALUE};
        send_batch(words);
        wait_drained();

        // Random part. Batch sizes are random, with a few fixed ones: one batch
        // exactly at capacity and one past it, so both are always present. The
        // long receiver hold-off starts with the fourth batch while the sender
        // keeps going, a few batches run with no idling on either side, and at
        // one point the sender pauses until all sorted words are out.
        batch_idx = 0;
        while (words_offered < RANDOM_WORDS + 20)
        begin
            case (batch_idx)
                1:       size = CAPACITY;
                2:       size = CAPACITY + 4;
                default: size = pick_batch_size();
            endcase
            if (batch_idx == 3)
                holds_requested++;
            no_idle = (batch_idx >= 6 && batch_idx <= 8);
            if (batch_idx == 10)
                wait_drained();
            words.delete();
            for (int i = 0; i < size; i++)
                words.push_back(pick_value());
            send_batch(words);
            batch_idx++;
        end
        no_idle  = 1'b0;
        in_valid = 1'b0;

        // Wait for the last sorted words, then give the block a while longer to
        // show any word that it should not send.
        wait_drained();
        repeat (CAPACITY + 8) @(negedge clk);

        $display("Sent %0d batches (%0d past capacity, %0d single-word), %0d words in total;",
                 batches_sent, overflow_batches, single_batches, words_offered);
        $display("checked %0d sorted words under random stalls and a %0d-cycle hold-off.",
                 checked_count, LONG_HOLD);
        if (fail_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
